/* hw/rtl/lia_pkg.sv */
// ----------------------------------------------------------------------------
// lia_pkg
// shared types and constants for the 64-bit long integer alu
// ----------------------------------------------------------------------------
package lia_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned CmdW   = 3;
    localparam int unsigned ShiftW = 6;
    localparam int unsigned QueueDepthDefault = 4;

    typedef enum logic [CmdW-1:0] {
        CMD_MUL = 3'd0,
        CMD_DIV = 3'd1,
        CMD_REM = 3'd2,
        CMD_SHL = 3'd3,
        CMD_SAR = 3'd4,
        CMD_SHR = 3'd5,
        CMD_NOP6 = 3'd6,
        CMD_NOP7 = 3'd7
    } t_cmd;

    // classified operation handed from front to back
    typedef struct packed {
        logic             is_mul;
        logic             is_div;
        logic             is_rem;
        logic             is_shift;
        logic             dz;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] shift_res;
    } t_op;

endpackage

/* hw/rtl/lia_front.sv */
// ----------------------------------------------------------------------------
// lia_front
// accepts transactions, decodes the command, does shifts and zero checks
// ----------------------------------------------------------------------------
module lia_front (
    input  logic [lia_pkg::CmdW-1:0]  i_cmd,
    input  logic [lia_pkg::DataW-1:0] i_a,
    input  logic [lia_pkg::DataW-1:0] i_b,
    output lia_pkg::t_op              o_op
);
    import lia_pkg::*;

    logic [ShiftW-1:0] sh;
    logic              b_zero;
    t_cmd              cmd;

    assign sh     = i_b[ShiftW-1:0];
    assign b_zero = (i_b == '0);
    assign cmd    = t_cmd'(i_cmd);

    // decode and shifter
    always_comb begin
        o_op           = '0;
        o_op.a         = i_a;
        o_op.b         = i_b;
        unique case (cmd)
            CMD_MUL: o_op.is_mul = 1'b1;
            CMD_DIV: begin
                o_op.is_div = !b_zero;
                o_op.dz     = b_zero;
            end
            CMD_REM: begin
                o_op.is_rem = !b_zero;
                o_op.dz     = b_zero;
            end
            CMD_SHL: begin
                o_op.is_shift  = 1'b1;
                o_op.shift_res = i_a << sh;
            end
            CMD_SAR: begin
                o_op.is_shift  = 1'b1;
                o_op.shift_res = DataW'($signed(i_a) >>> sh);
            end
            CMD_SHR: begin
                o_op.is_shift  = 1'b1;
                o_op.shift_res = i_a >> sh;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/lia_queue.sv */
// ----------------------------------------------------------------------------
// lia_queue
// short fifo between decode and execute
// ----------------------------------------------------------------------------
module lia_queue #(
    parameter int unsigned Depth = lia_pkg::QueueDepthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lia_pkg::t_op  i_op,
    output logic          o_valid,
    input  logic          i_stall,
    output lia_pkg::t_op  o_op
);
    import lia_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_op             r_mem [Depth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_stall = (r_cnt == (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_op;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

/* hw/rtl/lia_back.sv */
// ----------------------------------------------------------------------------
// lia_back
// pipelined execute: 3-stage multiplier and a pipelined radix-2 divider
// ----------------------------------------------------------------------------
module lia_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  lia_pkg::t_op              i_op,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lia_pkg::DataW-1:0] o_result_value,
    output logic                      o_div_by_zero
);
    import lia_pkg::*;

    // entry stage plus one stage per quotient bit; multiply shares the first three
    localparam int unsigned NSt = DataW + 1;
    localparam int unsigned HW  = DataW / 2;

    typedef struct packed {
        logic             vld;
        logic             is_mul;
        logic             is_div;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
        logic [DataW-1:0] dvs;
        logic [DataW-1:0] acc;
    } t_st;

    t_st  r_st [NSt];
    t_st  n_st [NSt];
    logic adv;

    // whole pipe moves when the last stage is free or taken
    assign adv     = !(r_st[NSt-1].vld && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_st[NSt-1].vld;

    // entry stage, then divider stages one bit each; multiply cross terms in stages 1 and 2
    always_comb begin
        logic             a_neg, b_neg;
        logic [DataW-1:0] lo_prod;
        a_neg        = i_op.a[DataW-1];
        b_neg        = i_op.b[DataW-1];
        lo_prod      = i_op.a[HW-1:0] * i_op.b[HW-1:0];
        n_st[0]      = '0;
        n_st[0].vld  = i_valid;
        n_st[0].is_mul = i_op.is_mul;
        n_st[0].is_div = i_op.is_div;
        n_st[0].dz   = i_op.dz;
        n_st[0].neg_q = i_op.is_div && (a_neg != b_neg);
        n_st[0].neg_r = i_op.is_rem && a_neg;
        if (i_op.is_div || i_op.is_rem) begin
            n_st[0].quo = a_neg ? (DataW'(0) - i_op.a) : i_op.a;
            n_st[0].dvs = b_neg ? (DataW'(0) - i_op.b) : i_op.b;
        end else if (i_op.is_mul) begin
            // stash operands: quo=a, dvs=b, acc = lo*lo
            n_st[0].quo = i_op.a;
            n_st[0].dvs = i_op.b;
            n_st[0].acc = lo_prod;
        end else begin
            n_st[0].acc = i_op.shift_res;
        end
        for (int k = 1; k < NSt; k++) begin
            logic [DataW:0] trial;
            n_st[k] = r_st[k-1];
            trial   = {r_st[k-1].rem, r_st[k-1].quo[DataW-1]};
            if (!r_st[k-1].is_mul && (k <= DataW)) begin
                n_st[k].quo = {r_st[k-1].quo[DataW-2:0], 1'b0};
                if (trial >= {1'b0, r_st[k-1].dvs}) begin
                    n_st[k].rem    = DataW'(trial - {1'b0, r_st[k-1].dvs});
                    n_st[k].quo[0] = 1'b1;
                end else begin
                    n_st[k].rem = trial[DataW-1:0];
                end
            end else if (r_st[k-1].is_mul && k == 1) begin
                n_st[k].rem = {r_st[k-1].quo[HW-1:0] * r_st[k-1].dvs[DataW-1:HW],
                               {HW{1'b0}}};
            end else if (r_st[k-1].is_mul && k == 2) begin
                n_st[k].acc = r_st[k-1].acc + r_st[k-1].rem
                            + {r_st[k-1].quo[DataW-1:HW] * r_st[k-1].dvs[HW-1:0],
                               {HW{1'b0}}};
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSt; k++) r_st[k].vld <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k < NSt; k++) r_st[k] <= n_st[k];
        end
    end

    // result select at the last stage
    always_comb begin
        t_st l;
        l = r_st[NSt-1];
        o_div_by_zero = l.dz;
        if (l.is_mul || l.dz) begin
            o_result_value = l.acc;
        end else if (l.is_div) begin
            o_result_value = l.neg_q ? (DataW'(0) - l.quo) : l.quo;
        end else if (l.dvs != '0) begin
            o_result_value = l.neg_r ? (DataW'(0) - l.rem) : l.rem;
        end else begin
            o_result_value = l.acc;
        end
    end

endmodule

/* hw/rtl/long_integer_alu_top.sv */
// ----------------------------------------------------------------------------
// long_integer_alu_top
// 64-bit long integer alu: mul, div, rem and shifts with java semantics
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_stall carries i_cmd, i_operand_a, i_operand_b.
//   output channel o_valid/i_stall carries o_result_value, o_div_by_zero.
//   a transaction moves when valid is high and stall is low.
//   one transaction per cycle is accepted while o_stall is low; operations are independent.
//   every command takes the same path: the queue, then a
//   65-stage execute pipe sized by the divider, which resolves one quotient
//   bit per stage. the multiplier uses three 32x32 products over the first
//   three stages and rides the same pipe so results leave in order.
//   shifts and zero-divisor checks are decided in the front decode.
//   a 4-entry queue separates decode from execute.
//   when the receiver stalls, the execute pipe holds and the queue fills;
//   o_stall rises once the queue is full.
//   reset (synchronous, active low) empties the queue and the pipe.
// ----------------------------------------------------------------------------
module long_integer_alu_top #(
    parameter int unsigned QueueDepth = lia_pkg::QueueDepthDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [lia_pkg::CmdW-1:0]  i_cmd,
    input  logic [lia_pkg::DataW-1:0] i_operand_a,
    input  logic [lia_pkg::DataW-1:0] i_operand_b,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lia_pkg::DataW-1:0] o_result_value,
    output logic                      o_div_by_zero
);
    import lia_pkg::*;

    t_op  dec_op, q_op;
    logic q_valid, q_stall;

    // decode
    lia_front u_front (
        .i_cmd (i_cmd),
        .i_a   (i_operand_a),
        .i_b   (i_operand_b),
        .o_op  (dec_op)
    );

    // decoupling queue
    lia_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (dec_op),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_op    (q_op)
    );

    // execute
    lia_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_stall        (q_stall),
        .i_op           (q_op),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_div_by_zero  (o_div_by_zero)
    );

`ifndef SYNTHESIS
    // stalled output holds its result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value)
                               && $stable(o_div_by_zero))
        else $error("output changed under stall");
    // a zero-divisor flag always comes with a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_result_value == '0)
        else $error("divide by zero with nonzero result");
    // the queue keeps a stalled entry valid until execute can advance
    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_stall |=> q_valid)
        else $error("queue dropped a stalled entry");
`endif

endmodule

/* test/long_integer_alu_top_tb.sv */
// ----------------------------------------------------------------------------
// long_integer_alu_top_tb
// self-checking bench: directed corner operations, a long receiver hold-off, then
// random traffic with bursty idling on both channels, checked in order against a
// local predictor
module long_integer_alu_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lia_pkg::*;

    localparam int unsigned NumRandom = 1030;
    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned DrainCycles = 80;
    localparam logic [63:0] MinVal = 64'h8000000000000000;
    localparam logic [63:0] MaxVal = 64'h7fffffffffffffff;

    typedef struct {
        logic [63:0] value;
        logic        dz;
    } t_alu_out;

    // expected result store and comparison
    class alu_scoreboard;
        t_alu_out pending[$];
        int unsigned errors;
        int unsigned checked;

        function logic [63:0] mag(logic [63:0] v);
            return v[63] ? (64'd0 - v) : v;
        endfunction

        function void note_input(t_cmd c, logic [63:0] a, logic [63:0] b);
            t_alu_out e;
            logic [63:0] q;
            logic [5:0] sh;
            sh = b[5:0];
            e.value = '0;
            e.dz = 1'b0;
            case (c)
                CMD_MUL: e.value = a * b;
                CMD_DIV, CMD_REM: begin
                    if (b == 0) begin
                        e.dz = 1'b1;
                    end else if (c == CMD_DIV) begin
                        q = mag(a) / mag(b);
                        e.value = (a[63] != b[63]) ? (64'd0 - q) : q;
                    end else begin
                        q = mag(a) % mag(b);
                        e.value = a[63] ? (64'd0 - q) : q;
                    end
                end
                CMD_SHL: e.value = a << sh;
                CMD_SAR: e.value = $signed(a) >>> sh;
                CMD_SHR: e.value = a >> sh;
                default: e.value = '0;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(logic [63:0] v, logic dz);
            t_alu_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h dz=%b", $time, v, dz);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.value !== v) begin
                $display("%0t: result_value expected %h actual %h", $time, e.value, v);
                errors++;
            end
            if (e.dz !== dz) begin
                $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, dz);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_value;
    logic        o_div_by_zero;

    alu_scoreboard sb;
    bit rx_idle_on = 1'b1;
    bit hold_rx = 1'b0;
    int unsigned idle_count = 0;
    int unsigned sent = 0;

    long_integer_alu_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_value(o_result_value),
        .o_div_by_zero(o_div_by_zero)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random operand with a bias toward interesting magnitudes
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MinVal;
            1: return MaxVal;
            2: return 64'(signed'($urandom_range(0, 6)) - 3);
            3: return {$urandom, $urandom} >> $urandom_range(0, 63);
            4: return -({32'd0, $urandom} >> $urandom_range(0, 31));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offer one transaction and wait for acceptance
    task automatic send_op(t_cmd c, logic [63:0] a, logic [63:0] b);
        i_valid <= 1'b1;
        i_cmd <= c;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(c, a, b);
        sent++;
    endtask

    task automatic idle_burst();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // receiver: stall bursts, a long hold-off on request
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // output monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_result_value, o_div_by_zero);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (idle_count >= IdleLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [63:0] a;
        logic [63:0] b;
        t_cmd c;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_op(CMD_MUL, MaxVal, MaxVal);
        send_op(CMD_MUL, MinVal, -64'd1);
        send_op(CMD_MUL, 64'hffffffff_ffffffff, 64'h12345678_9abcdef0);
        send_op(CMD_DIV, MinVal, -64'd1);
        send_op(CMD_REM, MinVal, -64'd1);
        send_op(CMD_DIV, 64'd12345, 64'd0);
        send_op(CMD_REM, MinVal, 64'd0);
        send_op(CMD_DIV, -64'd7, 64'd2);
        send_op(CMD_REM, -64'd7, 64'd2);
        send_op(CMD_DIV, 64'd7, -64'd2);
        send_op(CMD_REM, 64'd7, -64'd2);
        send_op(CMD_DIV, MinVal, MaxVal);
        send_op(CMD_REM, MaxVal, MinVal);
        send_op(CMD_SHL, 64'd1, 64'd63);
        send_op(CMD_SHL, MaxVal, 64'hffffffff_ffffffc1);
        send_op(CMD_SAR, MinVal, 64'd63);
        send_op(CMD_SAR, MinVal, 64'd64);
        send_op(CMD_SHR, MinVal, 64'd63);
        send_op(CMD_SHR, -64'd1, 64'h7fffffff_ffffff81);
        send_op(CMD_NOP6, MaxVal, MaxVal);
        send_op(CMD_NOP7, MinVal, 64'd0);
        send_op(CMD_DIV, 64'd0, MinVal);

        // sender pauses until everything has come back
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++) send_op(t_cmd'(i % 6), rand_operand(), rand_operand());

        // random traffic, idling stops for the last part
        for (int i = 0; i < NumRandom; i++) begin
            if (i == NumRandom - 150) rx_idle_on = 1'b0;
            if (rx_idle_on && $urandom_range(0, 9) == 0) idle_burst();
            c = t_cmd'($urandom_range(0, 7));
            if ($urandom_range(0, 15) != 0) c = t_cmd'($urandom_range(0, 5));
            a = rand_operand();
            b = rand_operand();
            if ((c == CMD_DIV || c == CMD_REM) && $urandom_range(0, 15) == 0) b = '0;
            send_op(c, a, b);
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        $display("sent %0d operations over all commands, %0d results checked",
                 sent, sb.checked);
        $display("covered div/rem corners, shift counts, overflow, stalls and hold-offs");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
